FILE: sv/cec_pkg.sv
`timescale 1ns / 1ps
package cec_pkg;

    localparam int LANES = 4;   // a_x, a_y, b_x, b_y
    localparam int QW    = 18;  // quotient bits of the response term
    localparam int DVW   = 52;  // divisor width: 2 * msum * dd
    localparam int NW    = 71;  // numerator width: 4 * mass * |q| + msum * dd
    localparam int IW    = 208;

    // a_pos_x, the last field declared, in the lowest bits
    typedef struct packed {
        logic [15:0] b_mass;
        logic [15:0] b_radius;
        logic [15:0] b_vel_y;
        logic [15:0] b_vel_x;
        logic [19:0] b_pos_y;
        logic [19:0] b_pos_x;
        logic [15:0] a_mass;
        logic [15:0] a_radius;
        logic [15:0] a_vel_y;
        logic [15:0] a_vel_x;
        logic [19:0] a_pos_y;
        logic [19:0] a_pos_x;
    } t_in;

    // lane 0 a_x, 1 a_y, 2 b_x, 3 b_y
    typedef struct packed {
        logic [LANES-1:0][15:0] vel;
        logic [LANES-1:0]       neg;
        logic                   hit;
    } t_side;

endpackage

FILE: sv/cec_front.sv
`timescale 1ns / 1ps
module cec_front import cec_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  t_in             i_data,
    output logic            o_valid,
    output logic [NW-1:0]   o_num [LANES],
    output logic [DVW-1:0]  o_dv,
    output t_side           o_side
);

    logic [8:0] r_v;

    // stage 1
    logic signed [20:0] r1_dx, r1_dy;
    logic signed [16:0] r1_dvx, r1_dvy;
    logic [16:0]        r1_rs, r1_msum;
    logic [15:0]        r1_am, r1_bm;
    logic [LANES-1:0][15:0] r1_vel;
    logic [15:0]        w_am, w_bm;

    // stage 2
    logic [40:0]        r2_dx2, r2_dy2;
    logic [33:0]        r2_rs2;
    logic signed [34:0] r2_px, r2_py;
    logic signed [17:0] r2_dx, r2_dy;
    logic [16:0]        r2_msum;
    logic [15:0]        r2_am, r2_bm;
    logic [LANES-1:0][15:0] r2_vel;
    logic signed [41:0] w_dx2, w_dy2;
    logic signed [34:0] w_px, w_py;

    // stage 3
    logic [41:0]        r3_dd;
    logic signed [35:0] r3_dot;
    logic [33:0]        r3_rs2;
    logic signed [17:0] r3_dx, r3_dy;
    logic [16:0]        r3_msum;
    logic [15:0]        r3_am, r3_bm;
    logic [LANES-1:0][15:0] r3_vel;

    // stage 4
    logic               r4_hit;
    logic [33:0]        r4_mlo, r4_mhi;
    logic [34:0]        r4_dmag;
    logic [16:0]        r4_dxm, r4_dym;
    logic [LANES-1:0]   r4_neg;
    logic [15:0]        r4_am, r4_bm;
    logic [LANES-1:0][15:0] r4_vel;
    logic [35:0]        w_dotu, w_dmag;
    logic [17:0]        w_dxu, w_dyu, w_dxm, w_dym;
    logic               w_nx, w_ny;

    // stage 5
    logic [50:0]        r5_msd;
    logic [34:0]        r5_xl, r5_yl;
    logic [33:0]        r5_xh, r5_yh;
    logic [15:0]        r5_am, r5_bm;
    logic               r5_hit;
    logic [LANES-1:0]   r5_neg;
    logic [LANES-1:0][15:0] r5_vel;

    // stage 6
    logic [51:0]        r6_qx, r6_qy;
    logic [50:0]        r6_msd;
    logic [15:0]        r6_am, r6_bm;
    t_side              r6_side;

    // stage 7
    logic [41:0]        r7_lo [LANES];
    logic [41:0]        r7_hi [LANES];
    logic [50:0]        r7_msd;
    t_side              r7_side;
    logic [51:0]        w_q  [LANES];
    logic [15:0]        w_mo [LANES];

    // stage 8
    logic [67:0]        r8_n [LANES];
    logic [50:0]        r8_msd;
    t_side              r8_side;

    // stage 9
    logic [NW-1:0]      r9_num [LANES];
    logic [DVW-1:0]     r9_dv;
    t_side              r9_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[7:0], i_valid};
        end
    end

    // a mass of zero counts as one
    assign w_am = (i_data.a_mass == 16'd0) ? 16'd1 : i_data.a_mass;
    assign w_bm = (i_data.b_mass == 16'd0) ? 16'd1 : i_data.b_mass;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx   <= $signed({1'b0, i_data.a_pos_x}) - $signed({1'b0, i_data.b_pos_x});
            r1_dy   <= $signed({1'b0, i_data.a_pos_y}) - $signed({1'b0, i_data.b_pos_y});
            r1_dvx  <= $signed({i_data.b_vel_x[15], i_data.b_vel_x})
                     - $signed({i_data.a_vel_x[15], i_data.a_vel_x});
            r1_dvy  <= $signed({i_data.b_vel_y[15], i_data.b_vel_y})
                     - $signed({i_data.a_vel_y[15], i_data.a_vel_y});
            r1_rs   <= {1'b0, i_data.a_radius} + {1'b0, i_data.b_radius};
            r1_am   <= w_am;
            r1_bm   <= w_bm;
            r1_msum <= {1'b0, w_am} + {1'b0, w_bm};
            r1_vel  <= {i_data.b_vel_y, i_data.b_vel_x, i_data.a_vel_y, i_data.a_vel_x};
        end
    end

    assign w_dx2 = r1_dx * r1_dx;
    assign w_dy2 = r1_dy * r1_dy;
    // the dot product only matters on a hit, where |d| < 2^17
    assign w_px  = r1_dvx * $signed(r1_dx[17:0]);
    assign w_py  = r1_dvy * $signed(r1_dy[17:0]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_dx2  <= w_dx2[40:0];
            r2_dy2  <= w_dy2[40:0];
            r2_rs2  <= r1_rs * r1_rs;
            r2_px   <= w_px;
            r2_py   <= w_py;
            r2_dx   <= $signed(r1_dx[17:0]);
            r2_dy   <= $signed(r1_dy[17:0]);
            r2_msum <= r1_msum;
            r2_am   <= r1_am;
            r2_bm   <= r1_bm;
            r2_vel  <= r1_vel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_dd   <= {1'b0, r2_dx2} + {1'b0, r2_dy2};
            r3_dot  <= $signed({r2_px[34], r2_px}) + $signed({r2_py[34], r2_py});
            r3_rs2  <= r2_rs2;
            r3_dx   <= r2_dx;
            r3_dy   <= r2_dy;
            r3_msum <= r2_msum;
            r3_am   <= r2_am;
            r3_bm   <= r2_bm;
            r3_vel  <= r2_vel;
        end
    end

    assign w_dotu = r3_dot;
    assign w_dmag = w_dotu[35] ? (~w_dotu + 36'd1) : w_dotu;
    assign w_dxu  = r3_dx;
    assign w_dyu  = r3_dy;
    assign w_dxm  = w_dxu[17] ? (~w_dxu + 18'd1) : w_dxu;
    assign w_dym  = w_dyu[17] ? (~w_dyu + 18'd1) : w_dyu;
    assign w_nx   = w_dotu[35] ^ w_dxu[17];
    assign w_ny   = w_dotu[35] ^ w_dyu[17];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_hit  <= (r3_dd != 42'd0) && (r3_dd < {8'd0, r3_rs2});
            r4_mlo  <= r3_msum * r3_dd[16:0];
            r4_mhi  <= r3_msum * r3_dd[33:17];
            r4_dmag <= w_dmag[34:0];
            r4_dxm  <= w_dxm[16:0];
            r4_dym  <= w_dym[16:0];
            r4_neg  <= {~w_ny, ~w_nx, w_ny, w_nx};
            r4_am   <= r3_am;
            r4_bm   <= r3_bm;
            r4_vel  <= r3_vel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_msd <= {17'd0, r4_mlo} + {r4_mhi, 17'd0};
            r5_xl  <= r4_dmag[17:0] * r4_dxm;
            r5_xh  <= r4_dmag[34:18] * r4_dxm;
            r5_yl  <= r4_dmag[17:0] * r4_dym;
            r5_yh  <= r4_dmag[34:18] * r4_dym;
            r5_am  <= r4_am;
            r5_bm  <= r4_bm;
            r5_hit <= r4_hit;
            r5_neg <= r4_neg;
            r5_vel <= r4_vel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_qx        <= {17'd0, r5_xl} + {r5_xh, 18'd0};
            r6_qy        <= {17'd0, r5_yl} + {r5_yh, 18'd0};
            r6_msd       <= r5_msd;
            r6_am        <= r5_am;
            r6_bm        <= r5_bm;
            r6_side.vel  <= r5_vel;
            r6_side.neg  <= r5_neg;
            r6_side.hit  <= r5_hit;
        end
    end

    // a lanes use the other circle's mass
    assign w_q[0]  = r6_qx;
    assign w_q[1]  = r6_qy;
    assign w_q[2]  = r6_qx;
    assign w_q[3]  = r6_qy;
    assign w_mo[0] = r6_bm;
    assign w_mo[1] = r6_bm;
    assign w_mo[2] = r6_am;
    assign w_mo[3] = r6_am;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < LANES; i++) begin
                r7_lo[i] <= w_q[i][25:0] * w_mo[i];
                r7_hi[i] <= w_q[i][51:26] * w_mo[i];
            end
            r7_msd  <= r6_msd;
            r7_side <= r6_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < LANES; i++) begin
                r8_n[i] <= {26'd0, r7_lo[i]} + {r7_hi[i], 26'd0};
            end
            r8_msd  <= r7_msd;
            r8_side <= r7_side;
        end
    end

    // num = 4*m*|q| + msum*dd, dv = 2*msum*dd: floor(num/dv) rounds half up
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < LANES; i++) begin
                r9_num[i] <= {1'b0, r8_n[i], 2'b00} + {20'd0, r8_msd};
            end
            r9_dv   <= {r8_msd, 1'b0};
            r9_side <= r8_side;
        end
    end

    assign o_valid = r_v[8];
    assign o_num   = r9_num;
    assign o_dv    = r9_dv;
    assign o_side  = r9_side;

endmodule

FILE: sv/cec_div.sv
`timescale 1ns / 1ps
module cec_div import cec_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [NW-1:0]   i_num [LANES],
    input  logic [DVW-1:0]  i_dv,
    input  t_side           i_side,
    output logic            o_valid,
    output logic [QW-1:0]   o_q [LANES],
    output t_side           o_side
);

    logic                 r_v    [QW];
    logic [NW-1:0]        r_rem  [QW][LANES];
    logic [QW-1:0]        r_q    [QW][LANES];
    logic [DVW-1:0]       r_dv   [QW];
    t_side                r_side [QW];

    // restoring division, one quotient bit per stage, MSB first
    for (genvar s = 0; s < QW; s++) begin : g_st
        localparam int K = QW - 1 - s;
        logic [NW-1:0]  w_rin [LANES];
        logic [QW-1:0]  w_qin [LANES];
        logic [DVW-1:0] w_dvin;
        t_side          w_sin;
        logic           w_vin;
        logic [NW-1:0]  w_dvs;
        logic [NW:0]    w_trial [LANES];
        logic [NW-1:0]  n_rem [LANES];
        logic [QW-1:0]  n_q   [LANES];

        if (s == 0) begin : g_first
            assign w_rin  = i_num;
            assign w_dvin = i_dv;
            assign w_sin  = i_side;
            assign w_vin  = i_valid;
            for (genvar l = 0; l < LANES; l++) begin : g_q0
                assign w_qin[l] = '0;
            end
        end else begin : g_next
            assign w_rin  = r_rem[s-1];
            assign w_qin  = r_q[s-1];
            assign w_dvin = r_dv[s-1];
            assign w_sin  = r_side[s-1];
            assign w_vin  = r_v[s-1];
        end

        assign w_dvs = {{(NW-DVW){1'b0}}, w_dvin} << K;

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                w_trial[l] = {1'b0, w_rin[l]} - {1'b0, w_dvs};
                if (!w_trial[l][NW]) begin
                    n_rem[l] = w_trial[l][NW-1:0];
                    n_q[l]   = {w_qin[l][QW-2:0], 1'b1};
                end else begin
                    n_rem[l] = w_rin[l];
                    n_q[l]   = {w_qin[l][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_q[s]    <= n_q;
                r_dv[s]   <= w_dvin;
                r_side[s] <= w_sin;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_q     = r_q[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

FILE: sv/cec_out.sv
`timescale 1ns / 1ps
module cec_out import cec_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [QW-1:0]   i_q [LANES],
    input  t_side           i_side,
    output logic            o_en,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [63:0]     o_m_tdata,
    output logic [1:0]      o_m_tuser
);

    logic signed [18:0] w_term [LANES];
    logic signed [19:0] w_sum  [LANES];
    logic [LANES-1:0][15:0] w_res;
    logic [LANES-1:0]   w_clip;
    logic [65:0]        w_word;

    logic        r_out_v, r_sk_v;
    logic [65:0] r_out, r_sk;
    logic        w_take;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_term[l] = i_side.neg[l] ? -$signed({1'b0, i_q[l]}) : $signed({1'b0, i_q[l]});
            w_sum[l]  = $signed({{4{i_side.vel[l][15]}}, i_side.vel[l]})
                      + $signed({w_term[l][18], w_term[l]});
            if (!i_side.hit) begin
                w_res[l]  = i_side.vel[l];
                w_clip[l] = 1'b0;
            end else if (w_sum[l][19:15] != 5'b00000 && w_sum[l][19:15] != 5'b11111) begin
                w_res[l]  = w_sum[l][19] ? 16'h8000 : 16'h7fff;
                w_clip[l] = 1'b1;
            end else begin
                w_res[l]  = w_sum[l][15:0];
                w_clip[l] = 1'b0;
            end
        end
    end

    // word layout: tuser {clipped, hit} above tdata
    assign w_word = {|w_clip, i_side.hit, w_res};

    // output register plus skid slot; the pipe stops only while the skid is full
    assign o_en   = !r_sk_v;
    assign w_take = r_out_v && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (!r_sk_v) begin
            if (!r_out_v || w_take) begin
                r_out_v <= i_valid;
            end else if (i_valid) begin
                r_sk_v <= 1'b1;
            end
        end else if (w_take) begin
            r_sk_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sk_v) begin
            if (!r_out_v || w_take) begin
                r_out <= w_word;
            end else begin
                r_sk <= w_word;
            end
        end else if (w_take) begin
            r_out <= r_sk;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out[63:0];
    assign o_m_tuser  = r_out[65:64];

endmodule

FILE: sv/circle_elastic_collision_response.sv
`timescale 1ns / 1ps
// Elastic collision response for one pair of circles per word. A pair is taken
// every cycle while o_s_tready is high and passes through 9 stages of geometry
// and multiplier partial products, an 18-stage restoring divider (one quotient
// bit per stage, four lanes sharing one divisor), and the output register. The
// normal-line velocity components are exchanged by the elastic rule when the
// centre distance is below the radius sum, rounded half away from zero and
// saturated to 16 bits; otherwise, or with coincident centres, the velocities
// pass through with hit low. Back-pressure is absorbed by a skid slot, so
// o_s_tready is a register and drops only while both output slots are full.
module circle_elastic_collision_response import cec_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_radius, a_mass,
    // b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_radius, b_mass
    input  logic [IW-1:0] i_s_tdata,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // a_new_vel_x, a_new_vel_y, b_new_vel_x, b_new_vel_y
    output logic [63:0]   o_m_tdata,
    // hit, clipped
    output logic [1:0]    o_m_tuser
);

    logic           w_en;
    logic           w_fv, w_dv_v;
    logic [NW-1:0]  w_num [LANES];
    logic [DVW-1:0] w_dv;
    t_side          w_fside, w_dside;
    logic [QW-1:0]  w_q [LANES];

    assign o_s_tready = w_en;

    cec_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_data  (t_in'(i_s_tdata)),
        .o_valid (w_fv),
        .o_num   (w_num),
        .o_dv    (w_dv),
        .o_side  (w_fside)
    );

    cec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fv),
        .i_num   (w_num),
        .i_dv    (w_dv),
        .i_side  (w_fside),
        .o_valid (w_dv_v),
        .o_q     (w_q),
        .o_side  (w_dside)
    );

    cec_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_dv_v),
        .i_q        (w_q),
        .i_side     (w_dside),
        .o_en       (w_en),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

FILE: sv/cec_chk.sv
`timescale 1ns / 1ps
module cec_chk import cec_pkg::*; (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_s_tvalid,
    input logic          o_s_tready,
    input logic [IW-1:0] i_s_tdata,
    input logic          o_m_tvalid,
    input logic          i_m_tready,
    input logic [63:0]   o_m_tdata,
    input logic [1:0]    o_m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result word changed");

    a_clip_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> !o_m_tuser[1])
        else $error("clipped set without hit");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && $past(o_m_tvalid))
        else $error("input stalled with no result held");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("output state not cleared by reset");

endmodule

bind circle_elastic_collision_response cec_chk u_cec_chk (.*);

FILE: sim/cec_checker.sv
`timescale 1ns / 1ps
module cec_checker import cec_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tready,
    input  logic [IW-1:0] i_s_tdata,
    input  logic          i_m_tvalid,
    input  logic          i_m_tready,
    input  logic [63:0]   i_m_tdata,
    input  logic [1:0]    i_m_tuser,
    output int            o_errors,
    output int            o_pending
);

    typedef struct packed {
        logic [15:0] a_vx;
        logic [15:0] a_vy;
        logic [15:0] b_vx;
        logic [15:0] b_vy;
        logic        hit;
        logic        clipped;
    } t_resp;

    t_resp resp_q[$];
    int    errors = 0;

    assign o_errors  = errors;
    assign o_pending = resp_q.size();

    // round(2*mo*q / (msum*den)), halves away from zero
    function automatic longint mass_share(longint q, longint mo, longint msum,
                                          longint den);
        longint mag, a, r, x, b, c, num;
        mag = q < 0 ? -q : q;
        a   = mag / den;
        r   = mag % den;
        x   = 2 * mo * a;
        b   = x / msum;
        c   = x % msum;
        num = 2 * (c * den + 2 * mo * r) + msum * den;
        b   = b + num / (2 * msum * den);
        return q < 0 ? -b : b;
    endfunction

    function automatic logic [15:0] clamp16(longint v, ref logic clip);
        if (v > 32767) begin
            clip = 1'b1;
            return 16'h7fff;
        end
        if (v < -32768) begin
            clip = 1'b1;
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    function automatic t_resp collide(t_in p);
        t_resp  r;
        longint dx, dy, dd, rs, am, bm, ms, dot;
        longint avx, avy, bvx, bvy, nax, nay, nbx, nby;
        logic   clip;
        avx = longint'($signed(p.a_vel_x));
        avy = longint'($signed(p.a_vel_y));
        bvx = longint'($signed(p.b_vel_x));
        bvy = longint'($signed(p.b_vel_y));
        dx  = longint'(p.a_pos_x) - longint'(p.b_pos_x);
        dy  = longint'(p.a_pos_y) - longint'(p.b_pos_y);
        dd  = dx * dx + dy * dy;
        rs  = longint'(p.a_radius) + longint'(p.b_radius);
        r.hit = dd != 0 && dd < rs * rs;
        nax = avx; nay = avy; nbx = bvx; nby = bvy;
        if (r.hit) begin
            am  = p.a_mass == 0 ? 1 : longint'(p.a_mass);
            bm  = p.b_mass == 0 ? 1 : longint'(p.b_mass);
            ms  = am + bm;
            dot = (bvx - avx) * dx + (bvy - avy) * dy;
            nax = avx + mass_share(dot * dx, bm, ms, dd);
            nay = avy + mass_share(dot * dy, bm, ms, dd);
            nbx = bvx + mass_share(-dot * dx, am, ms, dd);
            nby = bvy + mass_share(-dot * dy, am, ms, dd);
        end
        clip   = 1'b0;
        r.a_vx = clamp16(nax, clip);
        r.a_vy = clamp16(nay, clip);
        r.b_vx = clamp16(nbx, clip);
        r.b_vy = clamp16(nby, clip);
        r.clipped = clip;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_resp exp_r;
        if (i_rst_n && i_s_tvalid && i_s_tready)
            resp_q.insert(resp_q.size(), collide(t_in'(i_s_tdata)));
        if (i_rst_n && i_m_tvalid && i_m_tready) begin
            if (resp_q.size() == 0) begin
                $error("unexpected word %h/%b", i_m_tdata, i_m_tuser);
                errors++;
            end else begin
                exp_r = resp_q.pop_front();
                if (i_m_tdata[15:0] !== exp_r.a_vx) begin
                    $error("a_new_vel_x exp %h got %h", exp_r.a_vx, i_m_tdata[15:0]);
                    errors++;
                end
                if (i_m_tdata[31:16] !== exp_r.a_vy) begin
                    $error("a_new_vel_y exp %h got %h", exp_r.a_vy, i_m_tdata[31:16]);
                    errors++;
                end
                if (i_m_tdata[47:32] !== exp_r.b_vx) begin
                    $error("b_new_vel_x exp %h got %h", exp_r.b_vx, i_m_tdata[47:32]);
                    errors++;
                end
                if (i_m_tdata[63:48] !== exp_r.b_vy) begin
                    $error("b_new_vel_y exp %h got %h", exp_r.b_vy, i_m_tdata[63:48]);
                    errors++;
                end
                if (i_m_tuser[0] !== exp_r.hit) begin
                    $error("hit exp %b got %b", exp_r.hit, i_m_tuser[0]);
                    errors++;
                end
                if (i_m_tuser[1] !== exp_r.clipped) begin
                    $error("clipped exp %b got %b", exp_r.clipped, i_m_tuser[1]);
                    errors++;
                end
            end
        end
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import cec_pkg::*;

    localparam int N_RANDOM  = 1830;
    localparam int IDLE_LIMIT = 5000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [IW-1:0] s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [63:0]   m_tdata;
    logic [1:0]    m_tuser;
    int            errors, pending;
    int            idle_cycles = 0;
    int            hold_cnt = 0;
    bit            src_done = 1'b0;

    circle_elastic_collision_response DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser)
    );

    cec_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // valid stays high across back-to-back words
    task automatic send_pair(t_in p);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_tdata  <= p;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    function automatic t_in rand_pair(int kind);
        t_in p;
        int  sp;
        p = t_in'(IW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom}));
        if (kind < 80) begin
            // near pairs so that most of them overlap
            sp = 1 << $urandom_range(4, 17);
            p.b_pos_x = p.a_pos_x + 20'($urandom_range(0, sp)) - 20'(sp / 2);
            p.b_pos_y = p.a_pos_y + 20'($urandom_range(0, sp)) - 20'(sp / 2);
            p.a_radius = 16'($urandom_range(0, 2 * sp));
            p.b_radius = 16'($urandom_range(0, 2 * sp));
            if ($urandom_range(0, 3) == 0) begin
                p.a_vel_x = 16'($signed(p.a_vel_x) >>> 6);
                p.a_vel_y = 16'($signed(p.a_vel_y) >>> 6);
                p.b_vel_x = 16'($signed(p.b_vel_x) >>> 6);
                p.b_vel_y = 16'($signed(p.b_vel_y) >>> 6);
            end
            if ($urandom_range(0, 2) == 0) p.a_mass = 16'($urandom_range(1, 16));
        end
        if (p.a_mass == 16'd0) p.a_mass = 16'd1;
        if (p.b_mass == 16'd0) p.b_mass = 16'd1;
        return p;
    endfunction

    task automatic run_directed();
        t_in p;
        p = '0;
        p.a_mass = 16'd1; p.b_mass = 16'd1;
        p.a_radius = 16'hffff; p.b_radius = 16'hffff;
        p.a_vel_x = 16'h7fff; p.b_vel_x = 16'h8000;
        send_pair(p);                               // coincident centres
        p.b_pos_x = 20'hfffff; p.b_pos_y = 20'hfffff;
        send_pair(p);                               // far apart
        p.b_pos_x = 20'd100; p.b_pos_y = 20'd0;
        send_pair(p);                               // head-on, equal masses
        p.a_mass = 16'hffff;
        send_pair(p);
        p.b_mass = 16'hffff; p.a_mass = 16'd1;
        p.a_vel_y = 16'h8000; p.b_vel_y = 16'h7fff;
        p.b_pos_y = 20'd77;
        send_pair(p);
        p.a_pos_x = 20'hfffff; p.a_pos_y = 20'hfffff;
        p.b_pos_x = 20'hfff00; p.b_pos_y = 20'hfff40;
        p.a_vel_x = 16'd256; p.a_vel_y = 16'hff00; p.b_vel_x = 16'd0; p.b_vel_y = 16'd0;
        p.a_mass = 16'd3; p.b_mass = 16'd5;
        send_pair(p);
        p.a_radius = 16'd0; p.b_radius = 16'd0;
        send_pair(p);                               // zero radii never hit
        p.a_radius = 16'd100; p.b_radius = 16'd60;  // touching exactly: no hit
        p.b_pos_x = 20'hfffff - 20'd160; p.b_pos_y = 20'hfffff;
        send_pair(p);
        p.b_pos_x = 20'hfffff - 20'd159;
        send_pair(p);
        for (int i = 0; i < 10; i++) send_pair(rand_pair(0));
    endtask

    // sink stalls: mostly short, a few long
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            hold_cnt <= 0;
        end else if (hold_cnt != 0) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if ($urandom_range(0, 99) < 30) begin
            m_tready <= 1'b0;
            hold_cnt <= gap_len();
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("circle_elastic_collision_response: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        for (int i = 0; i < N_RANDOM; i++)
            send_pair(rand_pair($urandom_range(0, 99)));
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (errors == 0)
            $display("circle_elastic_collision_response: match");
        else
            $display("circle_elastic_collision_response: mismatch");
        $finish;
    end

endmodule
